/* rtl/tgp_pkg.sv */
// Shared widths, codes and types of the trilinear prolongation core.
`timescale 1ns / 1ps
`default_nettype none
package tgp_pkg;

   localparam int CELL_W       = 7;
   localparam int DATA_W       = 32;
   localparam int SUM_W        = DATA_W + 3;
   localparam int CSR_AW       = 4;
   localparam int CSR_DW       = 32;
   localparam int RSP_FIELDS_W = 3 * CELL_W + 8 * DATA_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int MAX_CELLS_I_DEF = 64;
   localparam int MAX_CELLS_J_DEF = 64;
   localparam int MAX_CELLS_K_DEF = 64;

   // upper clamp for cells_i; only the j/k extents size any storage
   localparam int MAX_CELLS_I = MAX_CELLS_I_DEF;

   typedef enum logic [1:0] {
      CSR_CELLS_I = 2'd0,
      CSR_CELLS_J = 2'd1,
      CSR_CELLS_K = 2'd2
   } csr_index_type;

   typedef logic signed [DATA_W-1:0] value_type;

   typedef struct packed {
      logic [CELL_W-1:0] i;
      logic [CELL_W-1:0] j;
      logic [CELL_W-1:0] k;
   } cells_type;

   typedef struct packed {
      logic [CELL_W-1:0] i;
      logic [CELL_W-1:0] j;
      logic [CELL_W-1:0] k;
      logic              emit;
      logic              last;
   } pos_type;

   // neighbors of one coarse point: 0 = this index, m = index minus one (order i,j,k)
   typedef struct packed {
      value_type c000;
      value_type c00m;
      value_type c0m0;
      value_type c0mm;
      value_type cm00;
      value_type cm0m;
      value_type cmm0;
      value_type cmmm;
   } taps_type;

   typedef struct packed {
      value_type same;
      value_type mid_k;
      value_type mid_j;
      value_type mid_i;
      value_type face_jk;
      value_type face_ik;
      value_type face_ij;
      value_type center;
   } fine_type;

endpackage
`default_nettype wire

/* rtl/tgp_csr.sv */
// Configuration registers (grid extents) behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module tgp_csr #(
   parameter int MAX_CELLS_J = tgp_pkg::MAX_CELLS_J_DEF,
   parameter int MAX_CELLS_K = tgp_pkg::MAX_CELLS_K_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tgp_pkg::CSR_AW-1:0]  paddr,
   input  logic [tgp_pkg::CSR_DW-1:0]  pwdata,
   output logic [tgp_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output tgp_pkg::cells_type          cells,
   output logic                        restart
);
   import tgp_pkg::*;

   logic [CELL_W-1:0] cells_i_ff, cells_i_in;
   logic [CELL_W-1:0] cells_j_ff, cells_j_in;
   logic [CELL_W-1:0] cells_k_ff, cells_k_in;
   logic              wr_en;
   csr_index_type     index;

   function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] r,
                                                     input int maxv);
      logic [CELL_W-1:0] res;
      if (r == '0) begin
         res = CELL_W'(1);
      end else if (int'(r) > maxv) begin
         res = CELL_W'(maxv);
      end else begin
         res = r;
      end
      return res;
   endfunction

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      cells_i_in = cells_i_ff;
      cells_j_in = cells_j_ff;
      cells_k_in = cells_k_ff;
      restart    = 1'b0;
      prdata     = '0;
      case (index)
         CSR_CELLS_I: begin
            prdata = CSR_DW'(cells_i_ff);
            if (wr_en) begin
               cells_i_in = pwdata[CELL_W-1:0];
               restart    = 1'b1;
            end
         end
         CSR_CELLS_J: begin
            prdata = CSR_DW'(cells_j_ff);
            if (wr_en) begin
               cells_j_in = pwdata[CELL_W-1:0];
               restart    = 1'b1;
            end
         end
         CSR_CELLS_K: begin
            prdata = CSR_DW'(cells_k_ff);
            if (wr_en) begin
               cells_k_in = pwdata[CELL_W-1:0];
               restart    = 1'b1;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_i_ff <= CELL_W'(1);
         cells_j_ff <= CELL_W'(1);
         cells_k_ff <= CELL_W'(1);
      end else begin
         cells_i_ff <= cells_i_in;
         cells_j_ff <= cells_j_in;
         cells_k_ff <= cells_k_in;
      end
   end

   assign cells.i = clamp_cells(cells_i_ff, MAX_CELLS_I);
   assign cells.j = clamp_cells(cells_j_ff, MAX_CELLS_J);
   assign cells.k = clamp_cells(cells_k_ff, MAX_CELLS_K);

endmodule
`default_nettype wire

/* rtl/tgp_scan.sv */
// Raster position counters and delay-store addresses for each request.
`timescale 1ns / 1ps
`default_nettype none
module tgp_scan #(
   parameter int MAX_CELLS_J = tgp_pkg::MAX_CELLS_J_DEF,
   parameter int MAX_CELLS_K = tgp_pkg::MAX_CELLS_K_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       restart,
   input  tgp_pkg::cells_type         cells,
   output tgp_pkg::pos_type           pos,
   output logic [$clog2((MAX_CELLS_J + 1) * (MAX_CELLS_K + 1))-1:0] plane_addr,
   output logic [$clog2(MAX_CELLS_K + 1)-1:0] row_addr
);
   import tgp_pkg::*;

   localparam int ROW_LEN     = MAX_CELLS_K + 1;
   localparam int PLANE_DEPTH = (MAX_CELLS_J + 1) * ROW_LEN;
   localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
   localparam int ROW_AW      = $clog2(ROW_LEN);

   logic [CELL_W-1:0] pos_i_ff, pos_i_in;
   logic [CELL_W-1:0] pos_j_ff, pos_j_in;
   logic [CELL_W-1:0] pos_k_ff, pos_k_in;
   logic [CELL_W-1:0] cur_i, cur_j, cur_k;
   logic              out_of_range;
   logic              i_wrap, j_wrap, k_wrap;

   always_comb begin
      // extents may have shrunk under a stale position: start over
      out_of_range = (pos_i_ff > cells.i) || (pos_j_ff > cells.j) || (pos_k_ff > cells.k);
      cur_i = out_of_range ? '0 : pos_i_ff;
      cur_j = out_of_range ? '0 : pos_j_ff;
      cur_k = out_of_range ? '0 : pos_k_ff;

      i_wrap = (cur_i == cells.i);
      j_wrap = (cur_j == cells.j);
      k_wrap = (cur_k == cells.k);

      pos.i    = cur_i;
      pos.j    = cur_j;
      pos.k    = cur_k;
      pos.emit = (cur_i != '0) && (cur_j != '0) && (cur_k != '0);
      pos.last = i_wrap && j_wrap && k_wrap;

      plane_addr = PLANE_AW'(int'(cur_j) * ROW_LEN + int'(cur_k));
      row_addr   = ROW_AW'(cur_k);

      pos_k_in = k_wrap ? '0 : cur_k + CELL_W'(1);
      pos_j_in = cur_j;
      pos_i_in = cur_i;
      if (k_wrap) begin
         pos_j_in = j_wrap ? '0 : cur_j + CELL_W'(1);
         if (j_wrap) begin
            pos_i_in = i_wrap ? '0 : cur_i + CELL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_i_ff <= '0;
         pos_j_ff <= '0;
         pos_k_ff <= '0;
      end else if (accept) begin
         pos_i_ff <= pos_i_in;
         pos_j_ff <= pos_j_in;
         pos_k_ff <= pos_k_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tgp_window.sv */
// Plane and row delay memories, window registers and the input stage.
`timescale 1ns / 1ps
`default_nettype none
module tgp_window #(
   parameter int MAX_CELLS_J = tgp_pkg::MAX_CELLS_J_DEF,
   parameter int MAX_CELLS_K = tgp_pkg::MAX_CELLS_K_DEF
) (
   input  logic                       clock,
   input  logic                       accept,
   input  logic                       advance,
   input  tgp_pkg::value_type         value,
   input  tgp_pkg::pos_type           pos,
   input  logic [$clog2((MAX_CELLS_J + 1) * (MAX_CELLS_K + 1))-1:0] plane_addr,
   input  logic [$clog2(MAX_CELLS_K + 1)-1:0] row_addr,
   output tgp_pkg::taps_type          taps,
   output tgp_pkg::pos_type           pos_a
);
   import tgp_pkg::*;

   localparam int ROW_LEN     = MAX_CELLS_K + 1;
   localparam int PLANE_DEPTH = (MAX_CELLS_J + 1) * ROW_LEN;
   localparam int ROW_AW      = $clog2(ROW_LEN);

   // plane_mem: previous plane by (j,k); cur_row_mem: this plane, row j-1;
   // prev_row_mem: previous plane, row j-1
   value_type plane_mem    [PLANE_DEPTH];
   value_type cur_row_mem  [ROW_LEN];
   value_type prev_row_mem [ROW_LEN];

   value_type          plane_rd_ff;
   value_type          cur_row_rd_ff;
   value_type          prev_row_rd_ff;
   value_type          value_a_ff;
   value_type          prev_a_ff;
   value_type          prev_value_ff;
   value_type          last_cm00_ff;
   value_type          last_cmm0_ff;
   value_type          last_c0m0_ff;
   pos_type            pos_a_ff;
   logic [ROW_AW-1:0]  row_addr_a_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         plane_rd_ff           <= plane_mem[plane_addr];
         plane_mem[plane_addr] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_row_rd_ff         <= cur_row_mem[row_addr];
         cur_row_mem[row_addr] <= value;
      end
   end

   // written as a value leaves the stage; the next read of that k is a row later
   always_ff @(posedge clock) begin
      if (advance) begin
         prev_row_mem[row_addr_a_ff] <= plane_rd_ff;
      end
      if (accept) begin
         prev_row_rd_ff <= prev_row_mem[row_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_a_ff    <= value;
         prev_a_ff     <= prev_value_ff;
         prev_value_ff <= value;
         pos_a_ff      <= pos;
         row_addr_a_ff <= row_addr;
      end
      if (advance) begin
         last_cm00_ff <= plane_rd_ff;
         last_cmm0_ff <= prev_row_rd_ff;
         last_c0m0_ff <= cur_row_rd_ff;
      end
   end

   assign taps.c000 = value_a_ff;
   assign taps.c00m = prev_a_ff;
   assign taps.c0m0 = cur_row_rd_ff;
   assign taps.c0mm = last_c0m0_ff;
   assign taps.cm00 = plane_rd_ff;
   assign taps.cm0m = last_cm00_ff;
   assign taps.cmm0 = prev_row_rd_ff;
   assign taps.cmmm = last_cmm0_ff;
   assign pos_a     = pos_a_ff;

endmodule
`default_nettype wire

/* rtl/tgp_mean.sv */
// Two-, four- and eight-point means with floor rounding.
`timescale 1ns / 1ps
`default_nettype none
module tgp_mean (
   input  tgp_pkg::taps_type taps,
   output tgp_pkg::fine_type fine
);
   import tgp_pkg::*;

   logic signed [SUM_W-1:0] s_000, s_00m, s_0m0, s_0mm, s_m00, s_m0m, s_mm0, s_mmm;
   logic signed [SUM_W-1:0] pair_k, pair_j, pair_i, pair_jm, pair_im, pair_mm;
   logic signed [SUM_W-1:0] quad_jk, quad_ik, quad_ij, oct;
   logic signed [SUM_W-1:0] sh_k, sh_j, sh_i, sh_jk, sh_ik, sh_ij, sh_c;

   function automatic logic signed [SUM_W-1:0] ext(input value_type x);
      return {{(SUM_W - DATA_W){x[DATA_W-1]}}, x};
   endfunction

   always_comb begin
      s_000 = ext(taps.c000);
      s_00m = ext(taps.c00m);
      s_0m0 = ext(taps.c0m0);
      s_0mm = ext(taps.c0mm);
      s_m00 = ext(taps.cm00);
      s_m0m = ext(taps.cm0m);
      s_mm0 = ext(taps.cmm0);
      s_mmm = ext(taps.cmmm);

      pair_k  = s_000 + s_00m;
      pair_j  = s_000 + s_0m0;
      pair_i  = s_000 + s_m00;
      pair_jm = s_0m0 + s_0mm;
      pair_im = s_m00 + s_m0m;
      pair_mm = s_mm0 + s_mmm;

      quad_jk = pair_k + pair_jm;
      quad_ik = pair_k + pair_im;
      quad_ij = pair_j + (s_m00 + s_mm0);
      oct     = quad_jk + pair_im + pair_mm;

      sh_k  = pair_k >>> 1;
      sh_j  = pair_j >>> 1;
      sh_i  = pair_i >>> 1;
      sh_jk = quad_jk >>> 2;
      sh_ik = quad_ik >>> 2;
      sh_ij = quad_ij >>> 2;
      sh_c  = oct >>> 3;

      fine.same    = taps.c000;
      fine.mid_k   = sh_k[DATA_W-1:0];
      fine.mid_j   = sh_j[DATA_W-1:0];
      fine.mid_i   = sh_i[DATA_W-1:0];
      fine.face_jk = sh_jk[DATA_W-1:0];
      fine.face_ik = sh_ik[DATA_W-1:0];
      fine.face_ij = sh_ij[DATA_W-1:0];
      fine.center  = sh_c[DATA_W-1:0];
   end

endmodule
`default_nettype wire

/* rtl/trilinear_grid_prolongation_core.sv */
// Top level of the streaming trilinear grid prolongation core.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   req      | in  | tvalid / tready    | coarse values, raster order (i, j, k inner)
//   rsp      | out | tvalid / tready    | cell index and eight fine values, tlast
//   csr      | in  | psel/penable/pready| cells_i @0x0, cells_j @0x4, cells_k @0x8
//
// One request per cycle sustained while results are taken. A request is registered
// with its delay-store reads (one read port per memory), then the means go into the
// result register. Ghost-layer requests give no result.
// Reset (synchronous) clears position and valids; the delay memories are not cleared.
// A stalled result holds; one more request may still enter the input stage.
`timescale 1ns / 1ps
`default_nettype none
module trilinear_grid_prolongation_core #(
   parameter int MAX_CELLS_J = tgp_pkg::MAX_CELLS_J_DEF,
   parameter int MAX_CELLS_K = tgp_pkg::MAX_CELLS_K_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tgp_pkg::DATA_W-1:0]     req_tdata,    // [31:0] coarse_value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [6:0] cell_i, [13:7] cell_j, [20:14] cell_k, [52:21] fine_same,
   // [84:53] fine_mid_k, [116:85] fine_mid_j, [148:117] fine_mid_i,
   // [180:149] fine_face_jk, [212:181] fine_face_ik, [244:213] fine_face_ij,
   // [276:245] fine_center, [279:277] zero
   output logic [tgp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,    // last_cell
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tgp_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [tgp_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [tgp_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import tgp_pkg::*;

   localparam int ROW_LEN     = MAX_CELLS_K + 1;
   localparam int PLANE_DEPTH = (MAX_CELLS_J + 1) * ROW_LEN;
   localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
   localparam int ROW_AW      = $clog2(ROW_LEN);

   cells_type               cells;
   logic                    restart;
   pos_type                 pos;
   pos_type                 pos_a;
   logic [PLANE_AW-1:0]     plane_addr;
   logic [ROW_AW-1:0]       row_addr;
   taps_type                taps;
   fine_type                fine;

   logic                    accept;
   logic                    advance;
   logic                    rsp_room;
   logic                    a_valid_ff, a_valid_in;
   logic                    r_valid_ff, r_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_last_ff;

   tgp_csr #(
      .MAX_CELLS_J (MAX_CELLS_J),
      .MAX_CELLS_K (MAX_CELLS_K)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cells   (cells),
      .restart (restart)
   );

   tgp_scan #(
      .MAX_CELLS_J (MAX_CELLS_J),
      .MAX_CELLS_K (MAX_CELLS_K)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (restart),
      .cells      (cells),
      .pos        (pos),
      .plane_addr (plane_addr),
      .row_addr   (row_addr)
   );

   tgp_window #(
      .MAX_CELLS_J (MAX_CELLS_J),
      .MAX_CELLS_K (MAX_CELLS_K)
   ) u_window (
      .clock      (clock),
      .accept     (accept),
      .advance    (advance),
      .value      (value_type'(req_tdata)),
      .pos        (pos),
      .plane_addr (plane_addr),
      .row_addr   (row_addr),
      .taps       (taps),
      .pos_a      (pos_a)
   );

   tgp_mean u_mean (
      .taps (taps),
      .fine (fine)
   );

   // ghost-layer requests leave the input stage without waiting on the output
   assign rsp_room   = !r_valid_ff || rsp_tready;
   assign advance    = a_valid_ff && (!pos_a.emit || rsp_room);
   assign req_tready = !a_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
      r_valid_in = r_valid_ff;
      if (advance && pos_a.emit) begin
         r_valid_in = 1'b1;
      end else if (rsp_tready) begin
         r_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pos_a.emit) begin
         rsp_data_ff <= {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                         fine.center, fine.face_ij, fine.face_ik, fine.face_jk,
                         fine.mid_i, fine.mid_j, fine.mid_k, fine.same,
                         pos_a.k, pos_a.j, pos_a.i};
         rsp_last_ff <= pos_a.last;
      end
   end

   assign rsp_tvalid = r_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && pos_a.emit && r_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while the input stage is stalled");

   a_rsp_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CELL_W-1:0] != '0) &&
                     (rsp_tdata[2*CELL_W-1:CELL_W] != '0) &&
                     (rsp_tdata[3*CELL_W-1:2*CELL_W] != '0))
      else $error("result for a ghost-layer position");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !a_valid_ff && !r_valid_ff)
      else $error("valids not cleared by reset");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (advance && pos_a.emit) |=> rsp_tvalid)
      else $error("result lost on load");
`endif

endmodule
`default_nettype wire

/* dv/prolongation_checker.sv */
// Checker for the trilinear prolongation core: predicts every fine block and compares results.
`timescale 1ns / 1ps
`default_nettype none
module prolongation_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [tgp_pkg::DATA_W-1:0]     req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [tgp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tgp_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [tgp_pkg::CSR_DW-1:0]     csr_pwdata,
   input  logic [tgp_pkg::CSR_DW-1:0]     csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending_cells
);
   import tgp_pkg::*;

   localparam int ROW_LEN   = MAX_CELLS_K_DEF + 1;
   localparam int PLANE_LEN = (MAX_CELLS_J_DEF + 1) * ROW_LEN;

   typedef struct {
      logic [CELL_W-1:0]            i;
      logic [CELL_W-1:0]            j;
      logic [CELL_W-1:0]            k;
      logic [7:0][DATA_W-1:0]       fine;
      logic                         last;
   } fine_block_type;

   const string fine_names[8] = '{"fine_same", "fine_mid_k", "fine_mid_j", "fine_mid_i",
                                  "fine_face_jk", "fine_face_ik", "fine_face_ij",
                                  "fine_center"};

   fine_block_type expected_blocks[$];
   cells_type      cells_reg;
   int             pos_i, pos_j, pos_k;
   value_type      plane_mem[PLANE_LEN];
   value_type      row_mem[ROW_LEN];
   value_type      prev_coarse, win_above, win_diag;
   int             mismatches = 0;

   initial begin
      foreach (plane_mem[n]) plane_mem[n] = '0;
      foreach (row_mem[n]) row_mem[n] = '0;
      prev_coarse = '0;
      win_above   = '0;
      win_diag    = '0;
   end

   function automatic int clamp_cells(input logic [CELL_W-1:0] reg_value, input int max_cells);
      if (reg_value == 0) return 1;
      if (reg_value > max_cells) return max_cells;
      return reg_value;
   endfunction

   // sums are exact in 64 bits; >>> floors toward minus infinity
   function automatic logic [DATA_W-1:0] floor_mean(input longint sum, input int shift);
      longint q;
      q = sum >>> shift;
      return q[DATA_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic predict_coarse(input value_type v);
      int ci, cj, ck, i, j, k, idx;
      value_type c00m, c0m0, c0mm, cm00, cm0m, cmm0, cmmm;
      longint s000, s00m, s0m0, s0mm, sm00, sm0m, smm0, smmm;
      fine_block_type blk;
      ci = clamp_cells(cells_reg.i, MAX_CELLS_I);
      cj = clamp_cells(cells_reg.j, MAX_CELLS_J_DEF);
      ck = clamp_cells(cells_reg.k, MAX_CELLS_K_DEF);
      i = pos_i;
      j = pos_j;
      k = pos_k;
      if (i > ci || j > cj || k > ck) begin
         i = 0;
         j = 0;
         k = 0;
      end
      idx = j * ROW_LEN + k;

      c00m = prev_coarse;
      c0m0 = (j > 0) ? plane_mem[idx - ROW_LEN] : '0;
      c0mm = (j > 0 && k > 0) ? plane_mem[idx - ROW_LEN - 1] : '0;
      cm00 = plane_mem[idx];
      cm0m = win_above;
      cmm0 = row_mem[k];
      cmmm = win_diag;

      plane_mem[idx] = v;
      row_mem[k]     = cm00;
      prev_coarse    = v;
      win_above      = cm00;
      win_diag       = cmm0;

      if (i > 0 && j > 0 && k > 0) begin
         s000 = v;
         s00m = c00m;
         s0m0 = c0m0;
         s0mm = c0mm;
         sm00 = cm00;
         sm0m = cm0m;
         smm0 = cmm0;
         smmm = cmmm;
         blk.i = CELL_W'(i);
         blk.j = CELL_W'(j);
         blk.k = CELL_W'(k);
         blk.fine[0] = v;
         blk.fine[1] = floor_mean(s000 + s00m, 1);
         blk.fine[2] = floor_mean(s000 + s0m0, 1);
         blk.fine[3] = floor_mean(s000 + sm00, 1);
         blk.fine[4] = floor_mean(s000 + s00m + s0m0 + s0mm, 2);
         blk.fine[5] = floor_mean(s000 + s00m + sm00 + sm0m, 2);
         blk.fine[6] = floor_mean(s000 + s0m0 + sm00 + smm0, 2);
         blk.fine[7] = floor_mean(s000 + s00m + s0m0 + s0mm + sm00 + sm0m + smm0 + smmm, 3);
         blk.last = (i == ci && j == cj && k == ck);
         expected_blocks.push_back(blk);
      end

      k++;
      if (k > ck) begin
         k = 0;
         j++;
         if (j > cj) begin
            j = 0;
            i++;
            if (i > ci) i = 0;
         end
      end
      pos_i = i;
      pos_j = j;
      pos_k = k;
   endtask

   task automatic check_block(input fine_block_type blk);
      if (rsp_tdata[CELL_W-1:0] !== blk.i)
         report_mismatch("cell_i", rsp_tdata[CELL_W-1:0], blk.i);
      if (rsp_tdata[2*CELL_W-1:CELL_W] !== blk.j)
         report_mismatch("cell_j", rsp_tdata[2*CELL_W-1:CELL_W], blk.j);
      if (rsp_tdata[3*CELL_W-1:2*CELL_W] !== blk.k)
         report_mismatch("cell_k", rsp_tdata[3*CELL_W-1:2*CELL_W], blk.k);
      for (int n = 0; n < 8; n++) begin
         if (rsp_tdata[3*CELL_W + DATA_W*n +: DATA_W] !== blk.fine[n])
            report_mismatch(fine_names[n], rsp_tdata[3*CELL_W + DATA_W*n +: DATA_W],
                            blk.fine[n]);
      end
      if (rsp_tlast !== blk.last) report_mismatch("last_cell", rsp_tlast, blk.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cells_reg.i = CELL_W'(1);
         cells_reg.j = CELL_W'(1);
         cells_reg.k = CELL_W'(1);
         pos_i = 0;
         pos_j = 0;
         pos_k = 0;
         expected_blocks.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_AW-1:2]))
               CSR_CELLS_I: begin
                  if (csr_pwrite) cells_reg.i = csr_pwdata[CELL_W-1:0];
                  else if (csr_prdata !== CSR_DW'(cells_reg.i))
                     report_mismatch("cells_i readback", csr_prdata, cells_reg.i);
               end
               CSR_CELLS_J: begin
                  if (csr_pwrite) cells_reg.j = csr_pwdata[CELL_W-1:0];
                  else if (csr_prdata !== CSR_DW'(cells_reg.j))
                     report_mismatch("cells_j readback", csr_prdata, cells_reg.j);
               end
               CSR_CELLS_K: begin
                  if (csr_pwrite) cells_reg.k = csr_pwdata[CELL_W-1:0];
                  else if (csr_prdata !== CSR_DW'(cells_reg.k))
                     report_mismatch("cells_k readback", csr_prdata, cells_reg.k);
               end
               default: ;
            endcase
            // any write to a mapped register restarts the stream
            if (csr_pwrite && csr_paddr[CSR_AW-1:2] <= CSR_CELLS_K) begin
               pos_i = 0;
               pos_j = 0;
               pos_k = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0)
               report_mismatch("result with no open cell", rsp_tdata[3*CELL_W-1:0], 0);
            else
               check_block(expected_blocks.pop_front());
         end
         if (req_tvalid && req_tready) predict_coarse(req_tdata);
      end
      pending_cells <= expected_blocks.size();
      fail_count    <= mismatches;
   end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Top of the prolongation core testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import tgp_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int SETTLE       = 10;
   localparam int HOLD_CYCLES  = 120;
   localparam logic [CSR_AW-1:0] CSR_UNMAPPED_ADDR = 4'hC;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [DATA_W-1:0]        req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_AW-1:0]        csr_paddr;
   logic [CSR_DW-1:0]        csr_pwdata;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   int fail_count;
   int pending_cells;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit hold_request  = 0;
   int cycle_count   = 0;

   trilinear_grid_prolongation_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   prolongation_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_cells (pending_cells)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic int clamp_cells(input int reg_value, input int max_cells);
      if (reg_value == 0) return 1;
      if (reg_value > max_cells) return max_cells;
      return reg_value;
   endfunction

   function automatic logic [DATA_W-1:0] random_coarse();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 16) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_coarse(input logic [DATA_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic csr_access(input logic write, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] data);
      @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ghost requests leave no trace in the checker, so allow the pipe to empty too
   task automatic drain();
      while (pending_cells != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_extents(input int ci, input int cj, input int ck);
      if ($urandom_range(0, 3) == 0) csr_access(1'b1, CSR_UNMAPPED_ADDR, $urandom);
      if ($urandom_range(0, 1) == 0) begin
         csr_access(1'b1, {CSR_CELLS_I, 2'b00}, ci);
         csr_access(1'b1, {CSR_CELLS_J, 2'b00}, cj);
         csr_access(1'b1, {CSR_CELLS_K, 2'b00}, ck);
      end else begin
         csr_access(1'b1, {CSR_CELLS_K, 2'b00}, ck);
         csr_access(1'b1, {CSR_CELLS_J, 2'b00}, cj);
         csr_access(1'b1, {CSR_CELLS_I, 2'b00}, ci);
      end
      csr_access(1'b0, {CSR_CELLS_I, 2'b00}, '0);
      csr_access(1'b0, {CSR_CELLS_J, 2'b00}, '0);
      csr_access(1'b0, {CSR_CELLS_K, 2'b00}, '0);
   endtask

   initial begin
      int phase;
      int random_items;
      int ci, cj, ck, grid_len, grids, count;
      bit cut_short;
      logic [DATA_W-1:0] mixed[8];

      mixed = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFE,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005, 32'hFFFF_FFF9};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset extents are 1x1x1: eight requests per grid, one cell out
      csr_access(1'b0, {CSR_CELLS_I, 2'b00}, '0);
      csr_access(1'b0, {CSR_CELLS_J, 2'b00}, '0);
      csr_access(1'b0, {CSR_CELLS_K, 2'b00}, '0);
      for (int n = 0; n < 8; n++) push_coarse(32'h7FFF_FFFF);
      for (int n = 0; n < 8; n++) push_coarse(32'h8000_0000);
      for (int n = 0; n < 8; n++) push_coarse(mixed[n]);
      end_burst();

      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: begin ci = 0;   cj = 0;   ck = 0;  end
            1: begin ci = 127; cj = 1;   ck = 1;  end
            2: begin ci = 1;   cj = 127; ck = 1;  end
            3: begin ci = 1;   cj = 1;   ck = 64; end
            4: begin ci = 3;   cj = 3;   ck = 3;  end
            5: begin ci = 65;  cj = 2;   ck = 3;  end
            default: begin
               ci = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
               cj = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
               ck = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            end
         endcase
         drain();
         set_extents(ci, cj, ck);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         grid_len = (clamp_cells(ci, MAX_CELLS_I) + 1) *
                    (clamp_cells(cj, MAX_CELLS_J_DEF) + 1) *
                    (clamp_cells(ck, MAX_CELLS_K_DEF) + 1);
         grids     = (grid_len > 100) ? 1 : $urandom_range(1, 3);
         cut_short = (phase == 6) || (phase > 6 && $urandom_range(0, 4) == 0);
         count     = grids * grid_len;
         // abandon the last grid part way; the next extent write restarts the stream
         if (cut_short) count = (grids - 1) * grid_len + $urandom_range(1, grid_len - 1);
         // sender keeps offering while the result side holds off
         if (phase == 4) hold_request = 1;
         for (int n = 0; n < count; n++) push_coarse(random_coarse());
         end_burst();
         random_items += count;
         phase++;
      end

      drain();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
